>>> hdl/assert_macros.svh
// Assertion macros shared by the keypad scanner modules.
// Needs signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KMS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define KMS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/kms_pkg.sv
// Types, constants and the code correction function for the keypad scanner.
// Used by kms_ctrl, kms_datapath and key_matrix_scan_debounce_top.
package kms_pkg;

   localparam int ROW_W       = 4;
   localparam int COL_W       = 3;
   localparam int CODE_W      = 7;
   localparam int HOLD_W      = 8;
   localparam int MAP_W       = 54;
   localparam int POS_W       = 7;
   localparam int HELD_MAX    = 3;
   localparam int HELD_CNT_W  = 2;
   localparam int KEY_ROW_STRIDE = 10;
   localparam int MAP_STRIDE  = 6;
   localparam int KEY_SPAN    = 6;
   localparam int GAP_ROWS    = 9;
   localparam logic [HOLD_W-1:0] DEBOUNCE_RESET = 8'd3;

   // Missing position of each row; zero means the row has none.
   localparam logic [3:0] ROW_GAP [0:GAP_ROWS-1] = '{
      4'd0, 4'd0, 4'd0, 4'd0, 4'd2, 4'd3, 4'd3, 4'd3, 4'd3
   };

   typedef logic [CODE_W-1:0] code_type;
   typedef logic [HOLD_W-1:0] hold_type;

   typedef struct packed {
      logic [ROW_W-1:0] row_index;
      logic [COL_W-1:0] col_index;
      logic             contact_closed;
      logic             report_enable;
   } req_type;

   typedef struct packed {
      logic             event_valid;
      code_type         key_code;
      logic             is_release;
      code_type         held_key_a;
      code_type         held_key_b;
      code_type         held_key_c;
      logic [MAP_W-1:0] scan_bits;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } kms_state_type;

   typedef struct packed {
      logic capture;
      logic walk;
      logic finish;
   } kms_cmd_type;

   typedef struct packed {
      logic last_slot;
      logic out_free;
   } kms_status_type;

   // Codes that fall behind a row's missing position move down by one.
   function automatic code_type fix_code(input code_type code);
      code_type lo;
      code_type result;
      result = code;
      for (int r = 0; r < GAP_ROWS; r++) begin
         lo = code_type'(ROW_GAP[r]) + code_type'((r + 1) * KEY_ROW_STRIDE);
         if (ROW_GAP[r] != 4'd0 && code >= lo && code < lo + code_type'(KEY_SPAN)) begin
            result = code - code_type'(1);
         end
      end
      return result;
   endfunction

endpackage

>>> hdl/key_matrix_scan_debounce_top.sv
// Channel   Handshake            Payload
// req       req_valid/req_stall  req_item  (kms_pkg::req_type)
// rsp       rsp_valid/rsp_stall  rsp_item  (kms_pkg::rsp_type)
// csr       csr_wr_en            csr_wr_data (debounce threshold)
//
// Each item passes through a capture, a walk over every slot of the table, and a
// load of the output register.
// The load waits while the output register is full and stalled; a new
// item is taken while a finished result still waits downstream.
// On reset the slot table and scan bitmap clear and the threshold goes to 3.
// Depends on kms_pkg, kms_ctrl and kms_datapath.
module key_matrix_scan_debounce_top #(
   parameter int ROWS       = 9,
   parameter int COLS       = 6,
   parameter int SLOTS      = 4,
   parameter int BIT_OFFSET = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  kms_pkg::req_type           req_item,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output kms_pkg::rsp_type           rsp_item,
   input  logic                       csr_wr_en,
   input  logic [kms_pkg::HOLD_W-1:0] csr_wr_data
);
   import kms_pkg::*;

   kms_cmd_type    cmd;
   kms_status_type status;

   kms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   kms_datapath #(
      .ROWS       (ROWS),
      .COLS       (COLS),
      .SLOTS      (SLOTS),
      .BIT_OFFSET (BIT_OFFSET)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_item    (req_item),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

>>> hdl/kms_ctrl.sv
// Sequencer for the keypad scanner: capture, slot walk, result load.
// Depends on kms_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kms_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  kms_pkg::kms_status_type status,
   output kms_pkg::kms_cmd_type    cmd
);
   import kms_pkg::*;

   kms_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = reset || (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.capture = 1'b1;
               state_in    = ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (status.last_slot) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold the finished item until the output register can take it.
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `KMS_ASSERT_NEXT(a_capture_walks, cmd.capture, state_ff == ST_WALK, "capture did not start the slot walk")
   `KMS_ASSERT_NEXT(a_last_slot_done, cmd.walk && status.last_slot, state_ff == ST_DONE, "walk did not end after the last slot")

endmodule

>>> hdl/kms_datapath.sv
// Slot table, scan bitmap, threshold register and output register.
// Depends on kms_pkg and assert_macros.svh; driven by kms_ctrl commands.
`include "assert_macros.svh"

module kms_datapath #(
   parameter int ROWS       = 9,
   parameter int COLS       = 6,
   parameter int SLOTS      = 4,
   parameter int BIT_OFFSET = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  kms_pkg::req_type           req_item,
   input  logic                       rsp_stall,
   output logic                       rsp_valid,
   output kms_pkg::rsp_type           rsp_item,
   input  logic                       csr_wr_en,
   input  logic [kms_pkg::HOLD_W-1:0] csr_wr_data,
   input  kms_pkg::kms_cmd_type       cmd,
   output kms_pkg::kms_status_type    status
);
   import kms_pkg::*;

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(ROWS);
   localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(COLS);

   code_type slot_key_ff  [0:SLOTS-1];
   code_type slot_key_in  [0:SLOTS-1];
   hold_type slot_hold_ff [0:SLOTS-1];
   hold_type slot_hold_in [0:SLOTS-1];
   code_type held_ff      [0:HELD_MAX-1];
   code_type held_in      [0:HELD_MAX-1];

   logic [MAP_W-1:0]      map_ff, map_in;
   hold_type              debounce_ff, debounce_in;
   req_type               item_ff, item_in;
   code_type              key_ff, key_in;
   logic                  in_range_ff, in_range_in;
   logic [SLOT_W-1:0]     slot_idx_ff, slot_idx_in;
   logic                  tracked_ff, tracked_in;
   logic                  free_found_ff, free_found_in;
   logic [SLOT_W-1:0]     free_idx_ff, free_idx_in;
   code_type              code_ff, code_in;
   logic                  release_ff, release_in;
   logic [HELD_CNT_W-1:0] nheld_ff, nheld_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   hold_type          thr;
   code_type          cur_key;
   hold_type          cur_hold;
   code_type          cur_fixed;
   hold_type          hold_inc;
   logic              key_match;
   logic              validated;
   logic              event_hit;
   logic              req_in_range;
   logic [POS_W-1:0]  bit_pos;

   assign thr       = (debounce_ff == '0) ? hold_type'(1) : debounce_ff;
   assign cur_key   = slot_key_ff[slot_idx_ff];
   assign cur_hold  = slot_hold_ff[slot_idx_ff];
   assign cur_fixed = fix_code(cur_key);
   assign hold_inc  = cur_hold + hold_type'(1);
   assign key_match = (cur_key == key_ff);
   assign validated = (cur_hold >= thr);
   assign event_hit = item_ff.report_enable && (code_ff != '0);

   assign req_in_range = (req_item.row_index < ROW_LIMIT) && (req_item.col_index < COL_LIMIT);
   assign bit_pos = POS_W'(req_item.row_index) * POS_W'(MAP_STRIDE)
                    + POS_W'(req_item.col_index) + POS_W'(BIT_OFFSET);

   assign status.last_slot = (slot_idx_ff == SLOT_W'(SLOTS - 1));
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_item         = rsp_ff;

   always_comb begin
      slot_key_in   = slot_key_ff;
      slot_hold_in  = slot_hold_ff;
      held_in       = held_ff;
      map_in        = map_ff;
      debounce_in   = csr_wr_en ? csr_wr_data : debounce_ff;
      item_in       = item_ff;
      key_in        = key_ff;
      in_range_in   = in_range_ff;
      slot_idx_in   = slot_idx_ff;
      tracked_in    = tracked_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      code_in       = code_ff;
      release_in    = release_ff;
      nheld_in      = nheld_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (cmd.capture) begin
         item_in       = req_item;
         key_in        = code_type'(req_item.row_index) * code_type'(KEY_ROW_STRIDE)
                         + code_type'(KEY_ROW_STRIDE) + code_type'(req_item.col_index)
                         + code_type'(1);
         in_range_in   = req_in_range;
         slot_idx_in   = '0;
         tracked_in    = 1'b0;
         free_found_in = 1'b0;
         free_idx_in   = '0;
         code_in       = '0;
         release_in    = 1'b0;
         nheld_in      = '0;
         for (int h = 0; h < HELD_MAX; h++) begin
            held_in[h] = '0;
         end
         // A sample at the first row and column starts a new scan.
         if (req_item.row_index == '0 && req_item.col_index == '0) begin
            map_in = '0;
         end
         if (req_in_range && req_item.contact_closed && bit_pos < POS_W'(MAP_W)) begin
            map_in = map_in | (MAP_W'(1) << bit_pos);
         end
      end

      if (cmd.walk) begin
         slot_idx_in = slot_idx_ff + SLOT_W'(1);
         if (in_range_ff) begin
            if (item_ff.contact_closed) begin
               if (key_match) begin
                  tracked_in = 1'b1;
                  if (!validated) begin
                     slot_hold_in[slot_idx_ff] = hold_inc;
                     if (hold_inc == thr) begin
                        code_in = cur_fixed;
                     end
                  end
               end else if (validated && nheld_ff != HELD_CNT_W'(HELD_MAX)) begin
                  held_in[nheld_ff] = cur_fixed;
                  nheld_in          = nheld_ff + HELD_CNT_W'(1);
               end
               if (!free_found_ff && cur_hold == '0) begin
                  free_found_in = 1'b1;
                  free_idx_in   = slot_idx_ff;
               end
            end else begin
               if (key_match && validated) begin
                  code_in                   = cur_fixed;
                  release_in                = 1'b1;
                  slot_hold_in[slot_idx_ff] = '0;
                  slot_key_in[slot_idx_ff]  = '0;
               end else if (validated && nheld_ff != HELD_CNT_W'(HELD_MAX)) begin
                  held_in[nheld_ff] = cur_fixed;
                  nheld_in          = nheld_ff + HELD_CNT_W'(1);
               end
            end
         end
      end

      if (cmd.finish) begin
         // An untracked closed key claims the first slot with a zero count.
         if (in_range_ff && item_ff.contact_closed && !tracked_ff && free_found_ff) begin
            slot_key_in[free_idx_ff] = key_ff;
         end
         rsp_in.event_valid = event_hit;
         rsp_in.key_code    = event_hit ? code_ff : '0;
         rsp_in.is_release  = event_hit && release_ff;
         rsp_in.held_key_a  = event_hit ? held_ff[0] : '0;
         rsp_in.held_key_b  = event_hit ? held_ff[1] : '0;
         rsp_in.held_key_c  = event_hit ? held_ff[2] : '0;
         rsp_in.scan_bits   = map_ff;
         rsp_valid_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) begin
            slot_key_ff[s]  <= '0;
            slot_hold_ff[s] <= '0;
         end
         map_ff       <= '0;
         debounce_ff  <= DEBOUNCE_RESET;
         rsp_valid_ff <= 1'b0;
         slot_idx_ff  <= '0;
      end else begin
         slot_key_ff  <= slot_key_in;
         slot_hold_ff <= slot_hold_in;
         map_ff       <= map_in;
         debounce_ff  <= debounce_in;
         rsp_valid_ff <= rsp_valid_in;
         slot_idx_ff  <= slot_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff       <= held_in;
      item_ff       <= item_in;
      key_ff        <= key_in;
      in_range_ff   <= in_range_in;
      tracked_ff    <= tracked_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      code_ff       <= code_in;
      release_ff    <= release_in;
      nheld_ff      <= nheld_in;
      rsp_ff        <= rsp_in;
   end

   `KMS_ASSERT_NEXT(a_finish_loads_output, cmd.finish, rsp_valid_ff, "finished item did not reach the output register")
   `KMS_ASSERT_NOW(a_quiet_without_event, rsp_valid_ff && !rsp_ff.event_valid, rsp_ff.key_code == '0 && rsp_ff.held_key_a == '0 && !rsp_ff.is_release, "fields set on a result without an event")

endmodule

>>> tb/kms_scan_checker.sv
// Scoreboard for key_matrix_scan_debounce_top: watches the sample, result and threshold ports,
// predicts each result from its own copy of the slot table and compares results in order.
// Depends on kms_pkg for the item types and field widths.
module kms_scan_checker #(
   parameter int ROWS       = 9,
   parameter int COLS       = 6,
   parameter int SLOTS      = 4,
   parameter int BIT_OFFSET = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  kms_pkg::req_type           req_item,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  kms_pkg::rsp_type           rsp_item,
   input  logic                       csr_wr_en,
   input  logic [kms_pkg::HOLD_W-1:0] csr_wr_data,
   output int                         fail_count,
   output int                         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import kms_pkg::*;

   code_type         key_of_slot [SLOTS];
   hold_type         hold_of_slot [SLOTS];
   logic [MAP_W-1:0] scan_map;
   hold_type         threshold;
   rsp_type          expected_results [$];
   int               mismatches = 0;

   assign fail_count = mismatches;

   // Rows 4 and up lack one position (column 2 in row 4, column 3 beyond), so
   // the codes from that position on move down by one.
   function automatic code_type shift_past_gap(input code_type code);
      int r;
      int lo;
      r = int'(code) / KEY_ROW_STRIDE - 1;
      if (r < 4) begin
         return code;
      end
      lo = (r + 1) * KEY_ROW_STRIDE + ((r == 4) ? 2 : 3);
      return (int'(code) >= lo && int'(code) < lo + KEY_SPAN) ? code - code_type'(1) : code;
   endfunction

   function automatic rsp_type predict_result(input req_type s);
      rsp_type  r;
      hold_type thr;
      code_type key;
      code_type code;
      code_type held [HELD_MAX];
      int       n_held;
      int       bitpos;
      logic     tracked;
      logic     released;
      r        = '0;
      thr      = (threshold == '0) ? hold_type'(1) : threshold;
      code     = '0;
      n_held   = 0;
      tracked  = 1'b0;
      released = 1'b0;
      foreach (held[j]) begin
         held[j] = '0;
      end
      if (s.row_index == '0 && s.col_index == '0) begin
         scan_map = '0;
      end
      if (int'(s.row_index) < ROWS && int'(s.col_index) < COLS) begin
         key = code_type'((int'(s.row_index) + 1) * KEY_ROW_STRIDE + int'(s.col_index) + 1);
         if (s.contact_closed) begin
            bitpos = int'(s.row_index) * MAP_STRIDE + int'(s.col_index) + BIT_OFFSET;
            if (bitpos < MAP_W) begin
               scan_map[bitpos] = 1'b1;
            end
            for (int i = 0; i < SLOTS; i++) begin
               if (key_of_slot[i] == key) begin
                  tracked = 1'b1;
                  if (hold_of_slot[i] < thr) begin
                     hold_of_slot[i]++;
                     if (hold_of_slot[i] == thr) begin
                        code = shift_past_gap(key_of_slot[i]);
                     end
                  end
               end else if (hold_of_slot[i] >= thr && n_held < HELD_MAX) begin
                  held[n_held] = shift_past_gap(key_of_slot[i]);
                  n_held++;
               end
            end
            // A new key only claims a slot; its count starts on the next closed sample.
            if (!tracked) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (hold_of_slot[i] == '0) begin
                     key_of_slot[i] = key;
                     break;
                  end
               end
            end
         end else begin
            for (int i = 0; i < SLOTS; i++) begin
               if (key_of_slot[i] == key && hold_of_slot[i] >= thr) begin
                  code            = shift_past_gap(key);
                  released        = 1'b1;
                  hold_of_slot[i] = '0;
                  key_of_slot[i]  = '0;
               end else if (hold_of_slot[i] >= thr && n_held < HELD_MAX) begin
                  held[n_held] = shift_past_gap(key_of_slot[i]);
                  n_held++;
               end
            end
         end
      end
      if (s.report_enable && code != '0) begin
         r.event_valid = 1'b1;
         r.key_code    = code;
         r.is_release  = released;
         r.held_key_a  = held[0];
         r.held_key_b  = held[1];
         r.held_key_c  = held[2];
      end
      r.scan_bits = scan_map;
      return r;
   endfunction

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (key_of_slot[i]) begin
            key_of_slot[i]  = '0;
            hold_of_slot[i] = '0;
         end
         scan_map  = '0;
         threshold = DEBOUNCE_RESET;
         expected_results.delete();
         pending_count <= 0;
      end else begin
         if (csr_wr_en) begin
            threshold = csr_wr_data;
         end
         if (req_valid && !req_stall) begin
            expected_results.push_back(predict_result(req_item));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               $display("%0t ns: result with no sample waiting, expected none, got key_code %0d",
                        $time, rsp_item.key_code);
            end else begin
               want = expected_results.pop_front();
               check_field("event_valid", 64'(want.event_valid), 64'(rsp_item.event_valid));
               check_field("key_code", 64'(want.key_code), 64'(rsp_item.key_code));
               check_field("is_release", 64'(want.is_release), 64'(rsp_item.is_release));
               check_field("held_key_a", 64'(want.held_key_a), 64'(rsp_item.held_key_a));
               check_field("held_key_b", 64'(want.held_key_b), 64'(rsp_item.held_key_b));
               check_field("held_key_c", 64'(want.held_key_c), 64'(rsp_item.held_key_c));
               check_field("scan_bits", 64'(want.scan_bits), 64'(rsp_item.scan_bits));
            end
         end
         pending_count <= expected_results.size();
      end
   end

endmodule

>>> tb/tb_top.sv
// Testbench top for key_matrix_scan_debounce_top: clock, reset, sample stimulus and the verdict.
// Depends on kms_pkg, the block itself and kms_scan_checker, which predicts and compares.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import kms_pkg::*;

   localparam int ROWS        = 9;
   localparam int COLS        = 6;
   localparam int SLOTS       = 4;
   localparam int BIT_OFFSET  = 0;
   localparam int CLK_PERIOD  = 10;
   localparam int CYCLE_LIMIT = 100000;
   localparam int PHASE_ITEMS = 45;
   localparam int MAX_LIVE    = 5;
   localparam int LONG_HOLD   = 80;
   localparam hold_type LATER_THRESHOLDS [5] = '{8'd0, 8'd2, 8'd5, 8'd4, 8'd3};

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   req_type           req_item    = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   rsp_type           rsp_item;
   logic              csr_wr_en   = 1'b0;
   logic [HOLD_W-1:0] csr_wr_data = '0;
   int                fail_count;
   int                pending_count;

   // Keys the random part treats as held down, so that most samples build up counts.
   bit sender_burst = 1'b0;
   int live_row [MAX_LIVE];
   int live_col [MAX_LIVE];
   int live_n = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   key_matrix_scan_debounce_top #(
      .ROWS       (ROWS),
      .COLS       (COLS),
      .SLOTS      (SLOTS),
      .BIT_OFFSET (BIT_OFFSET)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   kms_scan_checker #(
      .ROWS       (ROWS),
      .COLS       (COLS),
      .SLOTS      (SLOTS),
      .BIT_OFFSET (BIT_OFFSET)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_item      (rsp_item),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   task automatic sample(input int row, input int col, input bit closed, input bit enable);
      req_type s;
      int      gap;
      s.row_index      = row[ROW_W-1:0];
      s.col_index      = col[COL_W-1:0];
      s.contact_closed = closed;
      s.report_enable  = enable;
      gap = sender_burst ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= s;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic set_threshold(input hold_type value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Runs at the reset threshold of three: a key needs one sample to claim a
   // slot and three more to be reported.
   task automatic directed_samples();
      sample(15, 7, 1'b1, 1'b1);
      sample(9, 0, 1'b1, 1'b1);
      sample(0, 6, 1'b1, 1'b1);
      repeat (4) sample(8, 5, 1'b1, 1'b1);
      repeat (3) sample(4, 1, 1'b1, 1'b1);
      sample(4, 1, 1'b1, 1'b0);
      repeat (4) sample(0, 0, 1'b1, 1'b1);
      sample(3, 5, 1'b1, 1'b1);
      // The last slot holds only an uncounted claim, so this key takes it over.
      sample(5, 2, 1'b1, 1'b1);
      sample(8, 5, 1'b0, 1'b1);
      sample(4, 1, 1'b0, 1'b0);
      sample(1, 3, 1'b0, 1'b1);
      sample(0, 0, 1'b0, 1'b1);
      repeat (3) sample(3, 5, 1'b1, 1'b1);
      sample(3, 5, 1'b0, 1'b1);
   endtask

   task automatic random_phase(input int count);
      int pick;
      int k;
      int row;
      int col;
      bit enable;
      for (int n = 0; n < count; n++) begin
         if (n % 35 == 0) begin
            sender_burst = ($urandom_range(0, 3) == 0);
         end
         pick   = $urandom_range(0, 99);
         enable = ($urandom_range(0, 7) != 0);
         if (live_n == 0 || (pick < 12 && live_n < MAX_LIVE)) begin
            row = $urandom_range(0, ROWS - 1);
            col = $urandom_range(0, COLS - 1);
            live_row[live_n] = row;
            live_col[live_n] = col;
            live_n++;
            sample(row, col, 1'b1, enable);
         end else if (pick < 70) begin
            k = $urandom_range(0, live_n - 1);
            sample(live_row[k], live_col[k], 1'b1, enable);
         end else if (pick < 84) begin
            k   = $urandom_range(0, live_n - 1);
            row = live_row[k];
            col = live_col[k];
            live_n--;
            live_row[k] = live_row[live_n];
            live_col[k] = live_col[live_n];
            sample(row, col, 1'b0, enable);
         end else if (pick < 92) begin
            sample($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1),
                   1'($urandom_range(0, 1)), enable);
         end else if (pick < 95) begin
            sample(0, 0, 1'($urandom_range(0, 1)), enable);
         end else if (pick < 98) begin
            sample($urandom_range(ROWS, 15), $urandom_range(0, 7), 1'($urandom_range(0, 1)),
                   enable);
         end else begin
            sample($urandom_range(0, ROWS - 1), $urandom_range(COLS, 7),
                   1'($urandom_range(0, 1)), enable);
         end
      end
   endtask

   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_samples();
      wait_drained();
      set_threshold(8'd1);
      random_phase(PHASE_ITEMS);
      // With a threshold of one every counted key is validated, so opening
      // every position clears every counted slot before the long debounce.
      sender_burst = 1'b0;
      for (int r = 0; r < ROWS; r++) begin
         for (int c = 0; c < COLS; c++) begin
            sample(r, c, 1'b0, 1'b1);
         end
      end
      live_n = 0;
      wait_drained();
      set_threshold(8'd40);
      repeat (44) sample(2, 2, 1'b1, 1'b1);
      repeat (6) sample(6, 4, 1'b1, 1'b1);
      sample(2, 2, 1'b0, 1'b1);
      foreach (LATER_THRESHOLDS[k]) begin
         wait_drained();
         set_threshold(LATER_THRESHOLDS[k]);
         random_phase(PHASE_ITEMS);
      end
      wait_drained();
      repeat (SLOTS + 4) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Result side: random stalls, steady stretches, and one long hold-off that
   // lets the block fill up while samples keep coming.
   initial begin : receiver
      int  n;
      int  taken;
      bit  steady;
      taken  = 0;
      steady = 1'b0;
      forever begin
         if (taken % 32 == 0) begin
            steady = ($urandom_range(0, 3) == 0);
         end
         n = steady ? 0 : $urandom_range(0, 5);
         if (taken == 120) begin
            n = LONG_HOLD;
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         taken++;
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> files.f
+incdir+hdl
hdl/kms_pkg.sv
hdl/kms_ctrl.sv
hdl/kms_datapath.sv
hdl/key_matrix_scan_debounce_top.sv
tb/kms_scan_checker.sv
tb/tb_top.sv
